// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helper macros
// clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, cond, expr)
`define ASSERT_NEXT(label, cond, expr)

`endif

`endif

// File: design/lprl_pkg.sv
// ----------------------------------------------------------------------------
// lprl_pkg
// shared constants and types of the longest prefix route lookup
// ----------------------------------------------------------------------------
package lprl_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 8;
  localparam int CFG_W   = 8;
  localparam int SLOT_W  = 7;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register index, taken from paddr above the byte offset
  localparam logic [PADDR_W-3:0] REG_ENTRY_COUNT = '0;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] prefix;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  localparam int ENTRY_W = $bits(route_entry_t);

endpackage

// File: design/lprl_ram.sv
// ----------------------------------------------------------------------------
// lprl_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
module lprl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                            wr_data,
  input  logic                                        rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                            rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/longest_prefix_route_lookup.sv
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup
// ipv4 routing table with longest prefix match lookup
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid / in_stall) carries write and lookup items. a write
//   transfer stores prefix, mask, next hop and port at entry_index in the
//   table ram in the cycle it is taken; it gives no result.
//   a lookup transfer scans entries 0 .. min(entry_count, 128)-1, one entry
//   per cycle through the single read port of the table ram, keeping the
//   entry with the largest mask (earliest on a tie).
//   a lookup goes through the scan and wait states up to the result
//   register; the input is stalled for that whole time, so no new item is
//   taken until the lookup leaves the wait state, and writes go in at one
//   per cycle while no lookup is in progress.
//   the output channel (out_valid / out_stall) holds one result register; a
//   stalled result holds, and the next lookup scans meanwhile, waiting at the
//   end until the register is free.
//   entry_count is set through the apb port at byte address 0.
//   reset clears the control state and entry_count; table contents stay
//   undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module longest_prefix_route_lookup (
  input  logic                               clk,
  input  logic                               rst,
  // apb configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lprl_pkg::PADDR_W-1:0]       paddr,
  input  logic [lprl_pkg::PDATA_W-1:0]       pwdata,
  output logic [lprl_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  // input items
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               operation,
  input  logic [lprl_pkg::SLOT_W-1:0]        entry_index,
  input  logic [lprl_pkg::ADDR_W-1:0]        route_prefix,
  input  logic [lprl_pkg::ADDR_W-1:0]        route_mask,
  input  logic [lprl_pkg::ADDR_W-1:0]        route_next_hop,
  input  logic [lprl_pkg::PORT_W-1:0]        route_port,
  input  logic [lprl_pkg::ADDR_W-1:0]        dest_addr,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               found,
  output logic [lprl_pkg::ADDR_W-1:0]        hop_addr,
  output logic [lprl_pkg::PORT_W-1:0]        out_port,
  output logic [lprl_pkg::ADDR_W-1:0]        best_mask
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_WAIT = 3'b100
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [lprl_pkg::CFG_W-1:0]      entry_count;
  logic [lprl_pkg::CNT_W-1:0]      limit;
  logic [lprl_pkg::CNT_W-1:0]      limit_next;
  logic [lprl_pkg::CNT_W-1:0]      scan_idx;
  logic                            rd_pend;
  logic [lprl_pkg::ADDR_W-1:0]     dest;
  logic                            hit;
  logic [lprl_pkg::ADDR_W-1:0]     win_mask;
  logic [lprl_pkg::ADDR_W-1:0]     win_hop;
  logic [lprl_pkg::PORT_W-1:0]     win_port;

  logic                            in_xfer;
  logic                            cfg_wr;
  logic                            wr_en;
  logic                            rd_en;
  logic                            take_result;
  logic                            entry_match;
  logic                            entry_better;
  lprl_pkg::route_entry_t          wr_entry;
  lprl_pkg::route_entry_t          rd_entry;
  logic [lprl_pkg::ENTRY_W-1:0]    rd_data;

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite
                  && (paddr[lprl_pkg::PADDR_W-1:2] == lprl_pkg::REG_ENTRY_COUNT);
  assign prdata = (paddr[lprl_pkg::PADDR_W-1:2] == lprl_pkg::REG_ENTRY_COUNT)
                  ? lprl_pkg::PDATA_W'(entry_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wr) begin
      entry_count <= pwdata[lprl_pkg::CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------- table ram
  assign in_stall = (state != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  assign wr_en = in_xfer && (operation == lprl_pkg::OP_WRITE)
                 && (32'(entry_index) < 32'(lprl_pkg::TABLE_ENTRIES));
  assign wr_entry = '{prefix: route_prefix, mask: route_mask,
                      hop: route_next_hop, port: route_port};
  assign rd_en = (state == ST_SCAN) && (scan_idx < limit);

  lprl_ram #(
    .WIDTH (lprl_pkg::ENTRY_W),
    .DEPTH (lprl_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lprl_pkg::IDX_W'(entry_index)),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[lprl_pkg::IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_entry = lprl_pkg::route_entry_t'(rd_data);

  // ---------------------------------------------------------------- scan
  // count saturates at the table depth
  assign limit_next = (32'(entry_count) > 32'(lprl_pkg::TABLE_ENTRIES))
                      ? lprl_pkg::CNT_W'(lprl_pkg::TABLE_ENTRIES)
                      : lprl_pkg::CNT_W'(entry_count);

  assign entry_match  = ((dest & rd_entry.mask) == rd_entry.prefix);
  assign entry_better = !hit || (rd_entry.mask > win_mask);
  assign take_result  = (state == ST_WAIT) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer && (operation == lprl_pkg::OP_LOOKUP)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // last compare lands at this edge once every read is issued
        if (scan_idx == limit) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (take_result) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      hit      <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (in_xfer && (operation == lprl_pkg::OP_LOOKUP)) begin
        scan_idx <= '0;
        hit      <= 1'b0;
      end else begin
        if (rd_en) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (rd_pend && entry_match) begin
          hit <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && (operation == lprl_pkg::OP_LOOKUP)) begin
      dest     <= dest_addr;
      limit    <= limit_next;
      win_mask <= '0;
      win_hop  <= '0;
      win_port <= '0;
    end else if (rd_pend && entry_match && entry_better) begin
      win_mask <= rd_entry.mask;
      win_hop  <= rd_entry.hop;
      win_port <= rd_entry.port;
    end
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_result) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_result) begin
      found     <= hit;
      hop_addr  <= win_hop;
      out_port  <= win_port;
      best_mask <= win_mask;
    end
  end

  // ---------------------------------------------------------------- checks
  `ASSERT_IMPLIES(a_scan_in_range, state == ST_SCAN, scan_idx <= limit)
  `ASSERT_NEXT(a_pend_after_issue, rd_en, rd_pend && (state != ST_IDLE))
  `ASSERT_IMPLIES(a_miss_clears_best, (state == ST_WAIT) && !hit, (win_mask == '0) && (win_hop == '0) && (win_port == '0))
  `ASSERT_NEXT(a_result_from_wait, take_result, out_valid && (state == ST_IDLE))

endmodule
